/* hw/rtl/cbsm_pkg.sv */
// shared types, constants and helpers for the bank switch map
package cbsm_pkg;

    localparam int CPU_PAGES_DEF     = 8;
    localparam int PPU_PAGES_DEF     = 12;
    localparam int PRG_BANKS_MAX_DEF = 256;
    localparam int CHR_BANKS_MAX_DEF = 2048;

    localparam int BANK_W   = 12;
    localparam int REGION_W = 3;
    localparam int OFFSET_W = 21;

    localparam logic [2:0] REG_UNMAPPED = 3'd0;
    localparam logic [2:0] REG_IRAM     = 3'd1;
    localparam logic [2:0] REG_DUMMY    = 3'd2;
    localparam logic [2:0] REG_WRAM     = 3'd3;
    localparam logic [2:0] REG_PRG      = 3'd4;
    localparam logic [2:0] REG_CHR      = 3'd5;
    localparam logic [2:0] REG_CRAM     = 3'd6;
    localparam logic [2:0] REG_NT       = 3'd7;

    localparam logic [4:0] ACT_PRG8     = 5'd0;
    localparam logic [4:0] ACT_PRG16    = 5'd1;
    localparam logic [4:0] ACT_PRG32    = 5'd2;
    localparam logic [4:0] ACT_PRG32F   = 5'd3;
    localparam logic [4:0] ACT_CHR1     = 5'd4;
    localparam logic [4:0] ACT_CHR2     = 5'd5;
    localparam logic [4:0] ACT_CHR4     = 5'd6;
    localparam logic [4:0] ACT_CHR8     = 5'd7;
    localparam logic [4:0] ACT_CRAM1    = 5'd8;
    localparam logic [4:0] ACT_CRAM2    = 5'd9;
    localparam logic [4:0] ACT_CRAM4    = 5'd10;
    localparam logic [4:0] ACT_CRAM8    = 5'd11;
    localparam logic [4:0] ACT_NTBANK   = 5'd12;
    localparam logic [4:0] ACT_MIRROR   = 5'd13;
    localparam logic [4:0] ACT_NTFOUR   = 5'd14;
    localparam logic [4:0] ACT_CPU_XL   = 5'd15;
    localparam logic [4:0] ACT_PPU_XL   = 5'd16;

    // mirroring modes, anything above four-screen leaves the nametables alone
    localparam logic [2:0] MIR_HORZ     = 3'd0;
    localparam logic [2:0] MIR_VERT     = 3'd1;
    localparam logic [2:0] MIR_LOW      = 3'd2;
    localparam logic [2:0] MIR_HIGH     = 3'd3;
    localparam logic [2:0] MIR_FOUR     = 3'd4;

    localparam logic [0:0] CFG_PRG_COUNT = 1'd0;
    localparam logic [0:0] CFG_CHR_COUNT = 1'd1;

    // page table entry
    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [BANK_W-1:0]   bank;
    } t_entry;

    // one page write request to the table module
    typedef struct packed {
        logic        we;
        logic        ppu;
        logic [3:0]  page;
        t_entry      entry;
    } t_wr;

    function automatic logic is_writable(input logic [2:0] r);
        return (r == REG_IRAM) || (r == REG_WRAM) || (r == REG_CRAM) || (r == REG_NT);
    endfunction

endpackage

/* hw/rtl/cbsm_mod.sv */
// iterative restoring remainder of a bank number by a bank count
module cbsm_mod
    import cbsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [13:0] i_num,
    input  logic [12:0] i_den,
    output logic        o_done,
    output logic [12:0] o_rem
);
    localparam int NW = 14;

    logic [13:0] r_num, n_num;
    logic [13:0] r_rem, n_rem;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [12:0] r_den;
    logic [14:0] shifted;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        shifted = {r_rem, r_num[NW-1]};
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NW-2:0], 1'b0};
            if (shifted >= {2'b00, r_den}) begin
                n_rem = 14'(shifted - {2'b00, r_den});
            end else begin
                n_rem = shifted[13:0];
            end
            n_cnt = 4'(r_cnt + 4'd1);
            if (r_cnt == 4'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[12:0];
endmodule

/* hw/rtl/cbsm_tables.sv */
// cpu and ppu page table memories with reset-valid bits
module cbsm_tables
    import cbsm_pkg::*;
#(
    parameter int CPU_PAGES = CPU_PAGES_DEF,
    parameter int PPU_PAGES = PPU_PAGES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_wr    i_wr,
    input  logic   i_rd_ppu,
    input  logic [3:0] i_rd_page,
    output t_entry o_rd
);
    t_entry mem_cpu [CPU_PAGES];
    t_entry mem_ppu [PPU_PAGES];
    logic [CPU_PAGES-1:0] r_cpu_vld;
    logic [PPU_PAGES-1:0] r_ppu_vld;
    t_entry r_rd_raw;
    logic   r_rd_vld;
    logic   r_rd_ppu;
    logic [2:0] r_rd_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_vld <= '0;
            r_ppu_vld <= '0;
        end else if (i_wr.we) begin
            if (i_wr.ppu) r_ppu_vld[i_wr.page] <= 1'b1;
            else          r_cpu_vld[i_wr.page[2:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            if (i_wr.ppu) mem_ppu[i_wr.page] <= i_wr.entry;
            else          mem_cpu[i_wr.page[2:0]] <= i_wr.entry;
        end
        r_rd_ppu  <= i_rd_ppu;
        r_rd_page <= i_rd_page[2:0];
        if (i_rd_ppu) begin
            r_rd_raw <= mem_ppu[i_rd_page];
            r_rd_vld <= r_ppu_vld[i_rd_page];
        end else begin
            r_rd_raw <= mem_cpu[i_rd_page[2:0]];
            r_rd_vld <= r_cpu_vld[i_rd_page[2:0]];
        end
    end

    // entries never written read as their reset contents
    always_comb begin
        if (r_rd_vld) begin
            o_rd = r_rd_raw;
        end else begin
            o_rd.bank   = '0;
            o_rd.region = REG_UNMAPPED;
            if (!r_rd_ppu) begin
                unique case (r_rd_page)
                    3'd0:         o_rd.region = REG_IRAM;
                    3'd1, 3'd2:   o_rd.region = REG_DUMMY;
                    3'd3:         o_rd.region = REG_WRAM;
                    default:      o_rd.region = REG_UNMAPPED;
                endcase
            end
        end
    end
endmodule

/* hw/rtl/console_bank_switch_map_unit.sv */
// top level of the console bank switch map
//
// input channel: i_valid / o_stall with one request per action. set actions
// write up to eight page table entries; translate actions read one entry
// and return a single result on o_valid / i_stall.
// each action is handled by a small sequencer: per written page, program and
// character rom banks go through a 14-step restoring remainder unit, while
// character ram and nametable pages are written straight from the page state.
// for a translate, the read state registers the table entry and the output
// state then loads the result register.
// the input is stalled while an action is in flight or while a result waits
// in the output register; a held result keeps its value until taken.
// reset clears the valid bits of both page tables so they read as their
// power-up contents, clears the used flags, and sets both bank counts to 1.
// configuration writes land in the bank count registers at once.
module console_bank_switch_map_unit
    import cbsm_pkg::*;
#(
    parameter int CPU_PAGES     = CPU_PAGES_DEF,
    parameter int PPU_PAGES     = PPU_PAGES_DEF,
    parameter int PRG_BANKS_MAX = PRG_BANKS_MAX_DEF,
    parameter int CHR_BANKS_MAX = CHR_BANKS_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_action,
    input  logic [3:0]  i_page,
    input  logic [9:0]  i_bank,
    input  logic [9:0]  i_bank_b,
    input  logic [9:0]  i_bank_c,
    input  logic [9:0]  i_bank_d,
    input  logic [2:0]  i_mirror_mode,
    input  logic [15:0] i_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_region,
    output logic [20:0] o_offset,
    output logic        o_writable,
    output logic [7:0]  o_ram_groups
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAGE = 5'b00010,
        ST_MOD  = 5'b00100,
        ST_READ = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [8:0]  r_prg_cnt;
    logic [11:0] r_chr_cnt;

    logic [4:0]  r_act;
    logic [3:0]  r_page;
    logic [9:0]  r_b0, r_b1, r_b2, r_b3;
    logic [2:0]  r_mode;
    logic [15:0] r_addr;
    logic [3:0]  r_idx, r_cnt;   // step index and number of pages
    logic [7:0]  r_used;

    logic        r_ovalid;
    logic [2:0]  r_oreg;
    logic [20:0] r_ooff;
    logic        r_ow;

    logic        in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_cnt <= 9'd1;
            r_chr_cnt <= 12'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRG_COUNT: r_prg_cnt <= i_cfg_data[8:0];
                CFG_CHR_COUNT: r_chr_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective moduli
    logic [12:0] prg_mod, chr_mod;
    always_comb begin
        prg_mod = 13'(r_prg_cnt);
        if (r_prg_cnt == 9'd0) prg_mod = 13'd1;
        if (prg_mod > 13'(PRG_BANKS_MAX)) prg_mod = 13'(PRG_BANKS_MAX);
        chr_mod = 13'(r_chr_cnt);
        if (chr_mod > 13'(CHR_BANKS_MAX)) chr_mod = 13'(CHR_BANKS_MAX);
    end

    // per-step page, raw bank and kind
    logic        is_prg, is_chr, is_cram, is_nt;
    logic [4:0]  tgt_page;
    logic [13:0] raw_bank;
    logic [1:0]  nt_val;
    always_comb begin
        is_prg  = (r_act <= ACT_PRG32F);
        is_chr  = (r_act >= ACT_CHR1) && (r_act <= ACT_CHR8);
        is_cram = (r_act >= ACT_CRAM1) && (r_act <= ACT_CRAM8);
        is_nt   = !is_prg && !is_chr && !is_cram;
        tgt_page = 5'(r_page) + 5'(r_idx);
        raw_bank = 14'(r_b0) * 14'(r_cnt) + 14'(r_idx);
        nt_val   = r_b0[1:0];
        priority case (r_act)
            ACT_PRG32: tgt_page = 5'd4 + 5'(r_idx);
            ACT_PRG32F: begin
                tgt_page = 5'd4 + 5'(r_idx);
                unique case (r_idx[1:0])
                    2'd0: raw_bank = 14'(r_b0);
                    2'd1: raw_bank = 14'(r_b1);
                    2'd2: raw_bank = 14'(r_b2);
                    default: raw_bank = 14'(r_b3);
                endcase
            end
            ACT_CHR8, ACT_CRAM8: tgt_page = 5'(r_idx);
            ACT_MIRROR: begin
                tgt_page = 5'd8 + 5'(r_idx);
                priority case (r_mode)
                    MIR_HORZ: nt_val = {1'b0, r_idx[1]};
                    MIR_VERT: nt_val = {1'b0, r_idx[0]};
                    MIR_LOW:  nt_val = 2'd0;
                    MIR_HIGH: nt_val = 2'd1;
                    default:  nt_val = r_idx[1:0];
                endcase
            end
            ACT_NTFOUR: begin
                tgt_page = 5'd8 + 5'(r_idx);
                unique case (r_idx[1:0])
                    2'd0: nt_val = r_b0[1:0];
                    2'd1: nt_val = r_b1[1:0];
                    2'd2: nt_val = r_b2[1:0];
                    default: nt_val = r_b3[1:0];
                endcase
            end
            default: ;
        endcase
    end

    logic        page_ok;
    assign page_ok = is_prg ? (tgt_page < 5'(CPU_PAGES)) : (tgt_page < 5'(PPU_PAGES));

    // unknown mirroring modes leave the nametable pages as they are
    logic        mir_keep;
    assign mir_keep = (r_act == ACT_MIRROR) && (r_mode > MIR_FOUR);

    logic        mod_start, mod_done;
    logic [12:0] mod_rem;
    cbsm_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_num  (raw_bank),
        .i_den  (is_prg ? prg_mod : chr_mod),
        .o_done (mod_done),
        .o_rem  (mod_rem)
    );

    t_wr    wr;
    t_entry rd;
    logic   rd_ppu;
    logic [3:0] rd_page;
    assign rd_ppu  = (r_act == ACT_PPU_XL);
    assign rd_page = rd_ppu ? r_addr[13:10] : {1'b0, r_addr[15:13]};

    cbsm_tables #(.CPU_PAGES(CPU_PAGES), .PPU_PAGES(PPU_PAGES)) u_tab (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_ppu (rd_ppu),
        .i_rd_page(rd_page),
        .o_rd     (rd)
    );

    logic last;
    assign last = (r_idx == 4'(r_cnt - 4'd1));

    logic [7:0] n_used;
    always_comb begin
        n_state   = r_state;
        mod_start = 1'b0;
        wr        = '0;
        wr.ppu    = !is_prg;
        wr.page   = tgt_page[3:0];
        n_used    = r_used;
        unique case (r_state)
            ST_IDLE: if (in_acc) begin
                if (i_action == ACT_CPU_XL || i_action == ACT_PPU_XL) n_state = ST_READ;
                else if (i_action <= ACT_NTFOUR) n_state = ST_PAGE;
            end
            ST_PAGE: begin
                if ((is_prg || is_chr) && page_ok && !(is_chr && r_chr_cnt == 12'd0)) begin
                    mod_start = 1'b1;
                    n_state   = ST_MOD;
                end else begin
                    if (page_ok && is_cram) begin
                        wr.we = 1'b1;
                        wr.entry.region = REG_CRAM;
                        wr.entry.bank   = BANK_W'(raw_bank[4:0]);
                        n_used[raw_bank[4:2]] = 1'b1;
                    end else if (page_ok && is_nt && !mir_keep) begin
                        wr.we = 1'b1;
                        wr.entry.region = REG_NT;
                        wr.entry.bank   = BANK_W'(nt_val);
                    end
                    if (last) n_state = ST_IDLE;
                end
            end
            ST_MOD: if (mod_done) begin
                wr.we = 1'b1;
                wr.entry.region = is_prg ? REG_PRG : REG_CHR;
                wr.entry.bank   = mod_rem[BANK_W-1:0];
                n_state = last ? ST_IDLE : ST_PAGE;
            end
            ST_READ: n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    logic [3:0] act_cnt;
    always_comb begin
        unique case (i_action)
            ACT_PRG16, ACT_CHR2, ACT_CRAM2:            act_cnt = 4'd2;
            ACT_PRG32, ACT_PRG32F, ACT_CHR4, ACT_CRAM4,
            ACT_MIRROR, ACT_NTFOUR:                    act_cnt = 4'd4;
            ACT_CHR8, ACT_CRAM8:                       act_cnt = 4'd8;
            default:                                   act_cnt = 4'd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
            else if (out_acc)      r_ovalid <= 1'b0;
        end
        if (in_acc) begin
            r_act  <= i_action;
            r_page <= i_page;
            r_b0   <= i_bank;
            r_b1   <= i_bank_b;
            r_b2   <= i_bank_c;
            r_b3   <= i_bank_d;
            r_mode <= i_mirror_mode;
            r_addr <= i_address;
            r_cnt  <= act_cnt;
            r_idx  <= '0;
        end else if ((r_state == ST_PAGE && n_state == ST_PAGE)
                  || (r_state == ST_MOD && mod_done)) begin
            r_idx <= 4'(r_idx + 4'd1);
        end
        if (r_state == ST_OUT) begin
            if (rd_ppu && r_addr[15:10] >= 6'(PPU_PAGES)) begin
                r_oreg <= REG_UNMAPPED;
                r_ooff <= '0;
                r_ow   <= 1'b0;
            end else begin
                r_oreg <= rd.region;
                r_ow   <= is_writable(rd.region);
                if (rd_ppu) r_ooff <= 21'({rd.bank, 10'b0}) + 21'(r_addr[9:0]);
                else        r_ooff <= 21'({rd.bank, 13'b0}) + 21'(r_addr[12:0]);
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_region     = r_oreg;
    assign o_offset     = r_ooff;
    assign o_writable   = r_ow;
    assign o_ram_groups = r_used;

    // no new request while a result waits
    a_no_acc_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !in_acc) else $error("request accepted with result pending");
    // a result appears only after the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_OUT)) else $error("stray result");
    // page writes only while sequencing
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.we |-> (r_state == ST_PAGE || r_state == ST_MOD)) else $error("stray write");
endmodule

/* dv/tb.sv */
// testbench for the console bank switch map: predicted page tables, random requests
`timescale 1ns / 1ps

module tb;
    import cbsm_pkg::*;

    // mirroring mode that changes nothing
    localparam logic [2:0] MIR_NONE   = 3'd7;

    // worst set action is eight rom pages
    localparam int SETTLE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_PRG_COUNT;
    logic [11:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [4:0]  i_action = ACT_PRG8;
    logic [3:0]  i_page = '0;
    logic [9:0]  i_bank = '0;
    logic [9:0]  i_bank_b = '0;
    logic [9:0]  i_bank_c = '0;
    logic [9:0]  i_bank_d = '0;
    logic [2:0]  i_mirror_mode = MIR_HORZ;
    logic [15:0] i_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_region;
    logic [20:0] o_offset;
    logic        o_writable;
    logic [7:0]  o_ram_groups;

    console_bank_switch_map_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // one translate result
    typedef struct {
        logic [2:0]  region;
        logic [20:0] offset;
        logic        writable;
        logic [7:0]  ram_groups;
    } t_xlate;

    t_xlate xlate_q[$];

    // model of the page tables and bank counts
    int unsigned prg_count;
    int unsigned chr_count;
    logic [2:0]  cpu_region[8];
    int unsigned cpu_bank[8];
    logic [2:0]  ppu_region[12];
    int unsigned ppu_bank[12];
    logic [7:0]  cram_flags;

    int  errors = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 0;

    function automatic void map_reset();
        prg_count = 1;
        chr_count = 1;
        foreach (cpu_region[k]) begin
            cpu_region[k] = REG_UNMAPPED;
            cpu_bank[k] = 0;
        end
        cpu_region[0] = REG_IRAM;
        cpu_region[1] = REG_DUMMY;
        cpu_region[2] = REG_DUMMY;
        cpu_region[3] = REG_WRAM;
        foreach (ppu_region[k]) begin
            ppu_region[k] = REG_UNMAPPED;
            ppu_bank[k] = 0;
        end
        cram_flags = '0;
    endfunction

    function automatic void set_prg(int unsigned pg, int unsigned bk);
        int unsigned n;
        n = (prg_count == 0) ? 1 : prg_count;
        if (n > 256) n = 256;
        if (pg >= 8) return;
        cpu_region[pg] = REG_PRG;
        cpu_bank[pg] = bk % n;
    endfunction

    function automatic void set_chr(int unsigned pg, int unsigned bk);
        int unsigned n;
        n = chr_count;
        if (n == 0) return;
        if (n > 2048) n = 2048;
        if (pg >= 12) return;
        ppu_region[pg] = REG_CHR;
        ppu_bank[pg] = bk % n;
    endfunction

    function automatic void set_cram(int unsigned pg, int unsigned bk);
        if (pg >= 12) return;
        bk = bk & 32'h1F;
        ppu_region[pg] = REG_CRAM;
        ppu_bank[pg] = bk;
        cram_flags[bk >> 2] = 1'b1;
    endfunction

    function automatic void set_nt(int unsigned pg, int unsigned bk);
        if (pg >= 12) return;
        ppu_region[pg] = REG_NT;
        ppu_bank[pg] = bk & 3;
    endfunction

    function automatic void set_nt_four(int unsigned a, int unsigned b,
                                        int unsigned c, int unsigned d);
        set_nt(8, a);
        set_nt(9, b);
        set_nt(10, c);
        set_nt(11, d);
    endfunction

    function automatic logic is_writable_code(logic [2:0] rg);
        case (rg)
            REG_IRAM, REG_WRAM, REG_CRAM, REG_NT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // apply one request to the model, queue a translate result if any
    function automatic void map_request(logic [4:0] act, logic [3:0] pg, logic [9:0] b0,
                                        logic [9:0] b1, logic [9:0] b2, logic [9:0] b3,
                                        logic [2:0] mode, logic [15:0] addr);
        int unsigned n, idx;
        t_xlate r;
        r.region = REG_UNMAPPED;
        r.offset = '0;
        case (act)
            ACT_PRG8:   set_prg(pg, b0);
            ACT_PRG16:  for (int k = 0; k < 2; k++) set_prg(pg + k, b0 * 2 + k);
            ACT_PRG32:  for (int k = 0; k < 4; k++) set_prg(4 + k, b0 * 4 + k);
            ACT_PRG32F: begin
                set_prg(4, b0);
                set_prg(5, b1);
                set_prg(6, b2);
                set_prg(7, b3);
            end
            ACT_CHR1, ACT_CHR2, ACT_CHR4: begin
                n = 1 << (act - ACT_CHR1);
                for (int k = 0; k < n; k++) set_chr(pg + k, b0 * n + k);
            end
            ACT_CHR8:   for (int k = 0; k < 8; k++) set_chr(k, b0 * 8 + k);
            ACT_CRAM1, ACT_CRAM2, ACT_CRAM4: begin
                n = 1 << (act - ACT_CRAM1);
                for (int k = 0; k < n; k++) set_cram(pg + k, b0 * n + k);
            end
            ACT_CRAM8:  for (int k = 0; k < 8; k++) set_cram(k, b0 * 8 + k);
            ACT_NTBANK: set_nt(pg, b0);
            ACT_MIRROR: begin
                case (mode)
                    MIR_HORZ: set_nt_four(0, 0, 1, 1);
                    MIR_VERT: set_nt_four(0, 1, 0, 1);
                    MIR_LOW:  set_nt_four(0, 0, 0, 0);
                    MIR_HIGH: set_nt_four(1, 1, 1, 1);
                    MIR_FOUR: set_nt_four(0, 1, 2, 3);
                    default: ;
                endcase
            end
            ACT_NTFOUR: set_nt_four(b0, b1, b2, b3);
            ACT_CPU_XL: begin
                idx = addr[15:13];
                r.region = cpu_region[idx];
                r.offset = 21'(cpu_bank[idx] * 32'h2000 + addr[12:0]);
            end
            ACT_PPU_XL: begin
                idx = addr >> 10;
                if (idx < 12) begin
                    r.region = ppu_region[idx];
                    r.offset = 21'(ppu_bank[idx] * 32'h0400 + addr[9:0]);
                end
            end
            default: ;
        endcase
        if (act == ACT_CPU_XL || act == ACT_PPU_XL) begin
            r.writable = is_writable_code(r.region);
            r.ram_groups = cram_flags;
            xlate_q.push_back(r);
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request; valid stays high afterwards so back-to-back works
    task automatic send_request(logic [4:0] act, logic [3:0] pg, logic [9:0] b0,
                                logic [9:0] b1, logic [9:0] b2, logic [9:0] b3,
                                logic [2:0] mode, logic [15:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_page        <= pg;
        i_bank        <= b0;
        i_bank_b      <= b1;
        i_bank_c      <= b2;
        i_bank_d      <= b3;
        i_mirror_mode <= mode;
        i_address     <= addr;
        do @(posedge i_clk); while (o_stall);
        map_request(act, pg, b0, b1, b2, b3, mode, addr);
    endtask

    // lower valid, drain results, then let any set action finish
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (xlate_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [0:0] idx, logic [11:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PRG_COUNT) prg_count = value[8:0];
        else chr_count = value;
    endtask

    task automatic xlate_cpu(logic [15:0] addr);
        send_request(ACT_CPU_XL, 4'($urandom), 10'($urandom), 10'($urandom),
                     10'($urandom), 10'($urandom), 3'($urandom), addr);
    endtask

    task automatic xlate_ppu(logic [15:0] addr);
        send_request(ACT_PPU_XL, 4'($urandom), 10'($urandom), 10'($urandom),
                     10'($urandom), 10'($urandom), 3'($urandom), addr);
    endtask

    // power-up map, including ppu addresses past the table
    task automatic test_reset_map();
        xlate_cpu(16'h0000);
        xlate_cpu(16'h3FFF);
        xlate_cpu(16'h6123);
        xlate_cpu(16'hFFFF);
        xlate_ppu(16'h0000);
        xlate_ppu(16'h3000);
        xlate_ppu(16'hFFFF);
    endtask

    // program banks at the largest count, then sets that run past page 7
    task automatic test_prg_banks();
        write_count(CFG_PRG_COUNT, 12'd256);
        send_request(ACT_PRG8, 4'd7, 10'h3FF, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_PRG16, 4'd7, 10'd200, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_PRG32F, 4'd0, 10'd0, 10'd255, 10'd256, 10'h3FF, MIR_NONE, 0);
        xlate_cpu(16'hFFFF);
        xlate_cpu(16'h8000);
        send_request(ACT_PRG32, 4'd15, 10'h3FF, 0, 0, 0, MIR_NONE, 0);
        xlate_cpu(16'hE001);
    endtask

    // character rom at max count, then count 0 which ignores the sets
    task automatic test_chr_banks();
        write_count(CFG_CHR_COUNT, 12'd2048);
        send_request(ACT_CHR8, 4'd9, 10'h3FF, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_CHR4, 4'd10, 10'd5, 0, 0, 0, MIR_NONE, 0);
        xlate_ppu(16'h2FFF);
        xlate_ppu(16'h1C00);
        write_count(CFG_CHR_COUNT, 12'd0);
        send_request(ACT_CHR1, 4'd0, 10'd3, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_CHR2, 4'd2, 10'd3, 0, 0, 0, MIR_NONE, 0);
        xlate_ppu(16'h0000);
    endtask

    // character ram masking, used flags and nametable mirroring
    task automatic test_ram_pages();
        send_request(ACT_CRAM8, 4'd3, 10'h3FF, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_CRAM2, 4'd11, 10'd7, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_CRAM4, 4'd2, 10'd1, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_CRAM1, 4'd15, 10'd9, 0, 0, 0, MIR_NONE, 0);
        xlate_ppu(16'h0BFF);
        for (int m = 0; m < 8; m++) begin
            send_request(ACT_MIRROR, 0, 0, 0, 0, 0, 3'(m), 0);
            xlate_ppu(16'h2000 + 16'(m) * 16'h0400 % 16'h1000);
        end
        send_request(ACT_NTFOUR, 0, 10'h3FF, 10'd2, 10'd1, 10'd0, MIR_NONE, 0);
        send_request(ACT_NTBANK, 4'd12, 10'd1, 0, 0, 0, MIR_NONE, 0);
        send_request(ACT_NTBANK, 4'd0, 10'h3FE, 0, 0, 0, MIR_NONE, 0);
        send_request(5'd31, 4'd0, 0, 0, 0, 0, MIR_NONE, 0);
        xlate_ppu(16'h2C7F);
        xlate_ppu(16'h0000);
    endtask

    // set actions mixed with translates, slightly more sets, some unknown actions
    task automatic random_requests(int count);
        logic [4:0]  act;
        logic [15:0] addr;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 22) act = ACT_CPU_XL;
            else if (r < 44) act = ACT_PPU_XL;
            else if (r < 95) act = 5'($urandom_range(0, 14));
            else act = 5'($urandom_range(17, 31));
            addr = 16'($urandom);
            if (act == ACT_PPU_XL && $urandom_range(0, 9) < 8)
                addr = 16'($urandom_range(0, 16'h2FFF));
            send_request(act,
                         ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 11)) : 4'($urandom),
                         10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                         3'($urandom), addr);
            if (k % 60 == 59) no_gaps = ~no_gaps;
        end
    endtask

    task automatic test_random();
        logic [11:0] prg_set[5] = '{12'd1, 12'd0, 12'h1FF, 12'd3, 12'd0};
        logic [11:0] chr_set[5] = '{12'd8, 12'hFFF, 12'd1, 12'd0, 12'd100};
        for (int p = 0; p < 5; p++) begin
            write_count(CFG_PRG_COUNT, (p == 4) ? 12'($urandom_range(1, 256)) : prg_set[p]);
            write_count(CFG_CHR_COUNT, (p == 4) ? 12'($urandom) : chr_set[p]);
            random_requests(65);
            // hold off the sender until every result is back
            wait_drained();
            random_requests(65);
        end
    endtask

    // result checker, output stall pattern and watchdog
    int stall_left = 0;
    int free_left = 0;

    always @(posedge i_clk) begin
        t_xlate e;
        int r;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** console_bank_switch_map_unit: FAILED **");
                $finish;
            end
            if (o_valid && !i_stall) begin
                if (xlate_q.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    e = xlate_q.pop_front();
                    if (o_region !== e.region) begin
                        $error("region: expected %0d, got %0d", e.region, o_region);
                        errors++;
                    end
                    if (o_offset !== e.offset) begin
                        $error("offset: expected %h, got %h", e.offset, o_offset);
                        errors++;
                    end
                    if (o_writable !== e.writable) begin
                        $error("writable: expected %0d, got %0d", e.writable, o_writable);
                        errors++;
                    end
                    if (o_ram_groups !== e.ram_groups) begin
                        $error("ram_groups: expected %h, got %h", e.ram_groups, o_ram_groups);
                        errors++;
                    end
                end
            end
        end
        // stall pattern: short stalls, a few long ones, stall-free stretches
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (free_left > 0) begin
            i_stall <= 1'b0;
            free_left <= free_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            i_stall <= 1'b0;
            if (r < 10) free_left <= $urandom_range(20, 60);
            else begin
                stall_left <= (r < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                free_left <= $urandom_range(0, 4);
            end
        end
    end

    initial begin
        map_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_map();
        test_prg_banks();
        test_chr_banks();
        test_ram_pages();
        test_random();
        wait_drained();
        if (errors == 0) $display("** console_bank_switch_map_unit: PASSED **");
        else $display("** console_bank_switch_map_unit: FAILED **");
        $finish;
    end

endmodule
